@@ src/msb_first_bit_field_packer_core_defines.svh @@
// Assertion macros for the bit field packer RTL
`ifndef MSB_FIRST_BIT_FIELD_PACKER_CORE_DEFINES_SVH
`define MSB_FIRST_BIT_FIELD_PACKER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// condition and property checked on the same edge
`define MBFP_ASSERT_SAME(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);
// property checked on the edge after the condition
`define MBFP_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);
`else
`define MBFP_ASSERT_SAME(label, cond, prop, msg)
`define MBFP_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

@@ src/mbfp_pkg.sv @@
// Shared widths, operation codes and state encoding for the bit field packer
package mbfp_pkg;

   // field widths of one transaction
   localparam int OP_W     = 2;
   localparam int NBITS_W  = 7;
   localparam int VALUE_W  = 64;
   localparam int ADDR_W   = 10;
   localparam int LEN_W    = 11;
   localparam int DATA_W   = 8;
   localparam int BITPOS_W = 3;

   // widest field accepted, and the byte-aligned window that holds it
   localparam int FIELD_MAX = 64;
   localparam int WIN_W     = VALUE_W + DATA_W;

   localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MERGE,
      ST_WRITE,
      ST_RDATA,
      ST_RESP
   } state_type;

endpackage

@@ src/mbfp_req_if.sv @@
// Request channel: operation and its operands
interface mbfp_req_if import mbfp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [NBITS_W-1:0]   field_width;
   logic [VALUE_W-1:0]   field_value;
   logic [ADDR_W-1:0]    read_address;

   modport source (output valid, op, field_width, field_value, read_address, input ready);
   modport sink   (input valid, op, field_width, field_value, read_address, output ready);
endinterface

@@ src/mbfp_rsp_if.sv @@
// Response channel: status, read-back byte and write position
interface mbfp_rsp_if import mbfp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 status;
   logic [DATA_W-1:0]    read_data;
   logic [LEN_W-1:0]     byte_position;
   logic [BITPOS_W-1:0]  bit_position;

   modport source (output valid, status, read_data, byte_position, bit_position, input ready);
   modport sink   (input valid, status, read_data, byte_position, bit_position, output ready);
endinterface

@@ src/mbfp_byte_ram.sv @@
// Byte-wide buffer memory: one write port, one registered read port
module mbfp_byte_ram import mbfp_pkg::*; #(
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mbfp_ctrl.sv @@
// Sequencer and datapath: bounds check, byte read-modify-write, response register
`include "msb_first_bit_field_packer_core_defines.svh"

module mbfp_ctrl import mbfp_pkg::*; #(
   parameter int BUF_BYTES = 1024,
   localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   mbfp_req_if.sink          req,
   mbfp_rsp_if.source        rsp,
   input  logic [LEN_W-1:0]  buffer_length,
   output logic              mem_rd_en,
   output logic [AW-1:0]     mem_rd_addr,
   input  logic [DATA_W-1:0] mem_rd_data,
   output logic              mem_wr_en,
   output logic [AW-1:0]     mem_wr_addr,
   output logic [DATA_W-1:0] mem_wr_data
);

   // byte position 0..BUF_BYTES, bit position over the whole buffer, compare width
   localparam int BW   = $clog2(BUF_BYTES + 1);
   localparam int PW   = BW + BITPOS_W;
   localparam int CW   = ((PW > NBITS_W) ? PW : NBITS_W) + 1;
   localparam int SHW  = $clog2(WIN_W + 1);
   localparam int CNTW = $clog2(WIN_W / DATA_W + 1);
   localparam int SPW  = NBITS_W + 1;

   state_type              state_ff, state_in;

   // accepted transaction
   logic [OP_W-1:0]        op_ff;
   logic [NBITS_W-1:0]     nbits_ff;
   logic [VALUE_W-1:0]     value_ff;
   logic [ADDR_W-1:0]      addr_ff;

   // write position
   logic [BW-1:0]          byte_pos_ff, byte_pos_in;
   logic [BITPOS_W-1:0]    bit_pos_ff, bit_pos_in;

   // write sweep
   logic [WIN_W-1:0]       win_ff;
   logic [AW-1:0]          wr_addr_ff;
   logic [CNTW-1:0]        left_ff;
   logic                   first_old_ff;

   // result of the transaction in flight
   logic                   status_ff;
   logic [DATA_W-1:0]      data_ff;

   // response register
   logic                   rsp_valid_ff;
   logic                   rsp_status_ff;
   logic [DATA_W-1:0]      rsp_data_ff;
   logic [LEN_W-1:0]       rsp_byte_ff;
   logic [BITPOS_W-1:0]    rsp_bit_ff;

   logic [BW-1:0]          eff_len;
   logic [PW-1:0]          start_bits;
   logic [CW-1:0]          end_bits;
   logic [CW-1:0]          limit_bits;
   logic                   wr_ok;
   logic [SPW-1:0]         span;
   logic [CNTW-1:0]        nbytes;
   logic [VALUE_W-1:0]     field_mask;
   logic [SHW-1:0]         win_shift;
   logic [WIN_W-1:0]       win_next;
   logic                   rd_ok;
   logic                   rd_filled;
   logic                   rsp_free;
   logic                   rsp_load;
   logic                   req_ready;

   // length in use, capped at the memory size
   always_comb begin
      eff_len = (32'(buffer_length) < 32'(BUF_BYTES)) ? BW'(buffer_length) : BW'(BUF_BYTES);
   end

   // write bounds check and new position
   always_comb begin
      start_bits = {byte_pos_ff, bit_pos_ff};
      end_bits   = CW'(start_bits) + CW'(nbits_ff);
      limit_bits = CW'({eff_len, {BITPOS_W{1'b0}}});
      wr_ok      = (nbits_ff <= NBITS_W'(FIELD_MAX)) && (end_bits <= limit_bits);
   end

   // bytes touched and the field placed MSB first in a byte-aligned window
   always_comb begin
      span       = SPW'(bit_pos_ff) + SPW'(nbits_ff) + SPW'(DATA_W - 1);
      nbytes     = CNTW'(span >> BITPOS_W);
      field_mask = (nbits_ff >= NBITS_W'(FIELD_MAX)) ? '1
                 : ((VALUE_W'(1) << nbits_ff) - VALUE_W'(1));
      win_shift  = SHW'(WIN_W) - SHW'(bit_pos_ff) - SHW'(nbits_ff);
      win_next   = WIN_W'(value_ff & field_mask) << win_shift;
   end

   // read-back: in range, and written since the last clear (fill count is the position)
   always_comb begin
      rd_ok     = 32'(addr_ff) < 32'(eff_len);
      rd_filled = (32'(addr_ff) < 32'(byte_pos_ff))
               || ((32'(addr_ff) == 32'(byte_pos_ff)) && (bit_pos_ff != '0));
   end

   assign rsp_free = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            case (op_ff)
               OP_WRITE: state_in = (wr_ok && (nbits_ff != '0)) ? ST_MERGE : ST_RESP;
               OP_READ:  state_in = ST_RDATA;
               default:  state_in = ST_RESP;
            endcase
         end
         ST_MERGE, ST_WRITE: begin
            state_in = (left_ff == CNTW'(1)) ? ST_RESP : ST_WRITE;
         end
         ST_RDATA: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ready   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_wr_en   = 1'b0;
      rsp_load    = 1'b0;
      mem_rd_addr = (op_ff == OP_READ) ? AW'(addr_ff) : AW'(byte_pos_ff);
      mem_wr_addr = wr_addr_ff;
      mem_wr_data = win_ff[WIN_W-1 -: DATA_W];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_PREP: begin
            mem_rd_en = 1'b1;
         end
         ST_MERGE: begin
            // only the first byte can already hold bits
            mem_wr_en = 1'b1;
            if (first_old_ff) begin
               mem_wr_data = win_ff[WIN_W-1 -: DATA_W] | mem_rd_data;
            end
         end
         ST_WRITE: begin
            mem_wr_en = 1'b1;
         end
         ST_RDATA: begin
         end
         ST_RESP: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // position update, taken when the transaction is decoded
   always_comb begin
      byte_pos_in = byte_pos_ff;
      bit_pos_in  = bit_pos_ff;
      if (state_ff == ST_PREP) begin
         if ((op_ff == OP_WRITE) && wr_ok) begin
            {byte_pos_in, bit_pos_in} = end_bits[PW-1:0];
         end else if (op_ff == OP_CLEAR) begin
            byte_pos_in = '0;
            bit_pos_in  = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         byte_pos_ff  <= '0;
         bit_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         byte_pos_ff <= byte_pos_in;
         bit_pos_ff  <= bit_pos_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req_ready) begin
         op_ff    <= req.op;
         nbits_ff <= req.field_width;
         value_ff <= req.field_value;
         addr_ff  <= req.read_address;
      end

      case (state_ff)
         ST_PREP: begin
            win_ff       <= win_next;
            wr_addr_ff   <= AW'(byte_pos_ff);
            left_ff      <= nbytes;
            first_old_ff <= (bit_pos_ff != '0);
            data_ff      <= '0;
            case (op_ff)
               OP_WRITE: status_ff <= !wr_ok;
               OP_READ:  status_ff <= !rd_ok;
               OP_CLEAR: status_ff <= 1'b0;
               default:  status_ff <= 1'b1;
            endcase
         end
         ST_MERGE, ST_WRITE: begin
            win_ff     <= win_ff << DATA_W;
            wr_addr_ff <= wr_addr_ff + AW'(1);
            left_ff    <= left_ff - CNTW'(1);
         end
         ST_RDATA: begin
            data_ff <= (rd_ok && rd_filled) ? mem_rd_data : '0;
         end
         default: begin
         end
      endcase

      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= data_ff;
         rsp_byte_ff   <= LEN_W'(byte_pos_ff);
         rsp_bit_ff    <= bit_pos_ff;
      end
   end

   assign req.ready         = req_ready;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.read_data     = rsp_data_ff;
   assign rsp.byte_position = rsp_byte_ff;
   assign rsp.bit_position  = rsp_bit_ff;

   // checks
   `MBFP_ASSERT_SAME(a_wr_only_in_sweep, mem_wr_en,
                     (state_ff == ST_MERGE) || (state_ff == ST_WRITE),
                     "memory written outside a write sweep")
   `MBFP_ASSERT_SAME(a_pos_in_buffer, state_ff == ST_IDLE,
                     32'(byte_pos_ff) <= 32'(BUF_BYTES), "write position beyond buffer")
   `MBFP_ASSERT_NEXT(a_accept_decodes, req.valid && req_ready, state_ff == ST_PREP,
                     "accepted transaction not decoded")
   `MBFP_ASSERT_SAME(a_reject_no_data, rsp_valid_ff && rsp_status_ff, rsp_data_ff == '0,
                     "rejected transaction returned data")
   `MBFP_ASSERT_SAME(a_sweep_count, (state_ff == ST_MERGE) || (state_ff == ST_WRITE),
                     left_ff != '0, "byte sweep ran past its count")

endmodule

@@ src/msb_first_bit_field_packer_core.sv @@
// Top level of the MSB-first bit field packer
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        op, field_width, field_value, read_address
//   rsp_chan  out        valid/ready        status, read_data, byte_position, bit_position
//   csr       in         csr_we             csr_wdata (buffer_length)
//
// One transaction at a time. A write is decoded, then writes its first byte (merged with
// the old contents if that byte already holds bits) and the rest in order, up to 9 bytes
// for a 64-bit field, through the single byte-wide write port of the buffer memory; a read
// waits on the registered read port; clear and rejected writes go from decode to response.
// Reset is synchronous; no clearing pass is needed, since bytes beyond the write position
// read as zero. The response register lets a new transaction be accepted while the
// previous result waits; a stalled result only holds the next one in its response state.
module msb_first_bit_field_packer_core import mbfp_pkg::*; #(
   parameter int BUF_BYTES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   mbfp_req_if.sink          req_chan,
   mbfp_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [LEN_W-1:0]  csr_wdata
);

   localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

   logic [LEN_W-1:0]  buffer_length_ff;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;

   // buffer length register
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_length_ff <= LEN_RESET;
      end else if (csr_we) begin
         buffer_length_ff <= csr_wdata;
      end
   end

   mbfp_ctrl #(
      .BUF_BYTES (BUF_BYTES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .rsp           (rsp_chan),
      .buffer_length (buffer_length_ff),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data)
   );

   mbfp_byte_ram #(
      .DEPTH (BUF_BYTES)
   ) u_ram (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

endmodule
